// ===== hw/rtl/top_k_selector_with_attributes_core_macros.svh =====
// Assertion macros for the top-k selector core.
`ifndef TOP_K_SELECTOR_WITH_ATTRIBUTES_CORE_MACROS_SVH
`define TOP_K_SELECTOR_WITH_ATTRIBUTES_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TKS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define TKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tks_pkg.sv =====
// Shared types, constants and compare functions of the top-k selector.
`default_nettype none
package tks_pkg;

  localparam int VAL_W      = 32;
  localparam int ID_W       = 64;
  localparam int ATTR_W     = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int K_W        = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LARGEST = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_K_IN_USE     = 4'd1;

  localparam logic [K_W-1:0] K_IN_USE_RESET = 5'd16;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [ID_W-1:0]  ID_NONE = -64'sd1;

  typedef struct packed {
    logic signed [VAL_W-1:0]  value;
    logic signed [ID_W-1:0]   id;
    logic signed [ATTR_W-1:0] attr_a;
    logic signed [ATTR_W-1:0] attr_b;
  } entry_t;

  // Per-cycle commands broadcast along the cell row.
  typedef struct packed {
    logic insert;      // accepted candidate that passes the tail test
    logic shift;       // emit beat taken, move toward cell 0
    logic clear;       // refill with empty entries
    logic mode;        // current keep_largest
    logic clear_mode;  // mode whose neutral value the clear uses
  } cell_ctl_t;

  function automatic logic value_better(input logic mode,
                                        input logic signed [VAL_W-1:0] a,
                                        input logic signed [VAL_W-1:0] b);
    return mode ? (a > b) : (a < b);
  endfunction

  // Strict rank order: better value first, then smaller signed id.
  function automatic logic entry_better(input logic mode, input entry_t a, input entry_t b);
    if (a.value != b.value) begin
      return value_better(mode, a.value, b.value);
    end
    return a.id < b.id;
  endfunction

  function automatic entry_t neutral_entry(input logic mode);
    entry_t e;
    e.value  = mode ? VAL_MIN : VAL_MAX;
    e.id     = ID_NONE;
    e.attr_a = mode ? VAL_MIN : VAL_MAX;
    e.attr_b = mode ? VAL_MIN : VAL_MAX;
    return e;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tks_cell.sv =====
// One slot of the sorted insertion chain.
`default_nettype none
module tks_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tks_pkg::cell_ctl_t ctl,
  input  wire tks_pkg::entry_t    cand_i,
  input  wire tks_pkg::entry_t    left_i,
  input  wire logic               left_better_i,
  input  wire tks_pkg::entry_t    right_i,
  output tks_pkg::entry_t         entry_o,
  output logic                    better_o
);

  tks_pkg::entry_t entry_r;
  tks_pkg::entry_t entry_nxt;

  assign better_o = tks_pkg::entry_better(ctl.mode, cand_i, entry_r);
  assign entry_o  = entry_r;

  // Candidate lands in the first better slot; slots behind it take the left neighbor.
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.clear) begin
      entry_nxt = tks_pkg::neutral_entry(ctl.clear_mode);
    end else if (ctl.shift) begin
      entry_nxt = right_i;
    end else if (ctl.insert && better_o) begin
      entry_nxt = left_better_i ? left_i : cand_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= tks_pkg::neutral_entry(1'b0);
    end else begin
      entry_r <= entry_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tks_ctrl.sv =====
// Config registers, emit sequencer and chain command decode.
`default_nettype none
module tks_ctrl #(
  parameter int MAX_K = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_query_end,
  input  wire logic                             enter,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  rank_last,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tks_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tks_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic [((MAX_K > 1) ? $clog2(MAX_K) : 1)-1:0] klast,
  output tks_pkg::cell_ctl_t                    ctl
);

  localparam int IW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t                    state_r, state_nxt;
  logic [IW-1:0]             cnt_r, cnt_nxt;
  logic                      keep_largest_r, keep_largest_nxt;
  logic [tks_pkg::K_W-1:0]   k_in_use_r, k_in_use_nxt;
  logic                      in_fire, out_fire, cfg_fire, cfg_hit;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign cfg_ready = (state_r == ST_IDLE);

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign cfg_hit  = cfg_fire && ((cfg_index == tks_pkg::CFG_KEEP_LARGEST) ||
                                 (cfg_index == tks_pkg::CFG_K_IN_USE));

  // k clamped to 1..MAX_K, kept as last slot index
  always_comb begin
    if (k_in_use_r == '0) begin
      klast = '0;
    end else if (32'(k_in_use_r) > 32'(MAX_K)) begin
      klast = IW'(MAX_K - 1);
    end else begin
      klast = IW'(k_in_use_r - 5'd1);
    end
  end

  assign rank_last = (cnt_r == klast);

  always_comb begin
    keep_largest_nxt = keep_largest_r;
    k_in_use_nxt     = k_in_use_r;
    if (cfg_fire) begin
      unique case (cfg_index)
        tks_pkg::CFG_KEEP_LARGEST: keep_largest_nxt = cfg_wdata[0];
        tks_pkg::CFG_K_IN_USE:     k_in_use_nxt     = cfg_wdata[tks_pkg::K_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ctl.mode       = keep_largest_r;
    ctl.clear_mode = keep_largest_nxt;
    ctl.clear      = cfg_hit || (out_fire && rank_last);
    ctl.shift      = out_fire && !rank_last;
    ctl.insert     = in_fire && enter;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_query_end) begin
          state_nxt = ST_EMIT;
          cnt_nxt   = '0;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          if (rank_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cnt_r          <= '0;
      keep_largest_r <= 1'b0;
      k_in_use_r     <= tks_pkg::K_IN_USE_RESET;
    end else begin
      state_r        <= state_nxt;
      cnt_r          <= cnt_nxt;
      keep_largest_r <= keep_largest_nxt;
      k_in_use_r     <= k_in_use_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/top_k_selector_with_attributes_core.sv =====
// Top level of the streaming top-k selector: cell chain plus control.
//
//  channel | direction | beat carries
//  --------+-----------+---------------------------------------------------
//  in_     | in        | cand_value, cand_id, cand_attr_a/b, query_end
//  out_    | out       | best_value, best_id, best_attr_a/b, rank_last
//  cfg_    | in        | index (0 keep_largest, 1 k_in_use), wdata
//
// Candidates without query_end are taken one per cycle in idle, back to back.
// A query_end beat is inserted in its cycle, then k result beats leave cell 0
// one per cycle while out_ready is high, as the chain shifts left; in_ready
// stays low until the last beat is taken. Reset (rst_n low, synchronous)
// empties every slot and loads mode 0, k = 16. out_ stalls just freeze the
// chain; a write to either register empties the store.
`default_nettype none
`include "top_k_selector_with_attributes_core_macros.svh"
module top_k_selector_with_attributes_core #(
  parameter int MAX_K = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [31:0]             in_cand_value,
  input  wire logic signed [63:0]             in_cand_id,
  input  wire logic signed [31:0]             in_cand_attr_a,
  input  wire logic signed [31:0]             in_cand_attr_b,
  input  wire logic                           in_query_end,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [31:0]                  out_best_value,
  output logic signed [63:0]                  out_best_id,
  output logic signed [31:0]                  out_best_attr_a,
  output logic signed [31:0]                  out_best_attr_b,
  output logic                                out_rank_last,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tks_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  tks_pkg::cell_ctl_t ctl;
  tks_pkg::entry_t    cand;
  tks_pkg::entry_t    tail;
  tks_pkg::entry_t    neutral_ent;
  tks_pkg::entry_t    entries [MAX_K];
  logic [MAX_K-1:0]   better;
  logic [IW-1:0]      klast;
  logic               enter;

  always_comb begin
    cand.value  = in_cand_value;
    cand.id     = in_cand_id;
    cand.attr_a = in_cand_attr_a;
    cand.attr_b = in_cand_attr_b;
  end

  // Entry test: strictly better value than the worst kept slot (slot k-1).
  assign tail        = entries[klast];
  assign enter       = tks_pkg::value_better(ctl.mode, in_cand_value, tail.value);
  assign neutral_ent = tks_pkg::neutral_entry(ctl.mode);

  tks_ctrl #(
    .MAX_K (MAX_K)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_query_end (in_query_end),
    .enter        (enter),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rank_last    (out_rank_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .klast        (klast),
    .ctl          (ctl)
  );

  // Sorted row, best in cell 0. Each cell sees its left neighbor for
  // insertion and its right neighbor for the emit shift.
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    tks_pkg::entry_t left_ent;
    tks_pkg::entry_t right_ent;
    logic            left_bt;

    if (i == 0) begin : g_head
      assign left_ent = cand;
      assign left_bt  = 1'b0;
    end else begin : g_body
      assign left_ent = entries[i-1];
      assign left_bt  = better[i-1];
    end

    if (i == MAX_K - 1) begin : g_tail
      assign right_ent = neutral_ent;
    end else begin : g_mid
      assign right_ent = entries[i+1];
    end

    tks_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (ctl),
      .cand_i        (cand),
      .left_i        (left_ent),
      .left_better_i (left_bt),
      .right_i       (right_ent),
      .entry_o       (entries[i]),
      .better_o      (better[i])
    );
  end

  // Results always come from cell 0.
  assign out_best_value  = entries[0].value;
  assign out_best_id     = entries[0].id;
  assign out_best_attr_a = entries[0].attr_a;
  assign out_best_attr_b = entries[0].attr_b;

  // Query end always opens an emit sequence.
  `TKS_ASSERT_NEXT(a_end_starts_emit, clk, rst_n, in_valid && in_ready && in_query_end, out_valid, "query end did not start emission")
  // Emission runs until the rank_last beat.
  `TKS_ASSERT_NEXT(a_emit_continues, clk, rst_n, out_valid && out_ready && !out_rank_last, out_valid, "emission stopped early")
  // After the last beat the block is idle and the store is empty.
  `TKS_ASSERT_NEXT(a_last_clears, clk, rst_n, out_valid && out_ready && out_rank_last, !out_valid && (out_best_id == tks_pkg::ID_NONE), "store not cleared after last beat")
  // Input side is closed while results are pending.
  `TKS_ASSERT_NOW(a_no_overlap, clk, rst_n, out_valid, !in_ready && !cfg_ready, "input open during emission")

endmodule
`default_nettype wire

// ===== tb/sv/topk_rank_checker.sv =====
// Checker for the top-k selector: tracks the kept list, predicts ranked beats, compares.
module topk_rank_checker #(
  parameter int MAX_K = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [31:0]                  in_cand_value,
  input  logic signed [63:0]                  in_cand_id,
  input  logic signed [31:0]                  in_cand_attr_a,
  input  logic signed [31:0]                  in_cand_attr_b,
  input  logic                                in_query_end,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [31:0]                  out_best_value,
  input  logic signed [63:0]                  out_best_id,
  input  logic signed [31:0]                  out_best_attr_a,
  input  logic signed [31:0]                  out_best_attr_b,
  input  logic                                out_rank_last,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [tks_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tks_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output int                                  fails,
  output int                                  pending
);

  typedef struct packed {
    tks_pkg::entry_t slot;
    logic            last;
  } rank_beat_t;

  logic                    largest;
  logic [tks_pkg::K_W-1:0] k_reg;
  tks_pkg::entry_t         kept [MAX_K];
  rank_beat_t              ranked_due [$];

  // Unsigned key where smaller always means better, for either mode.
  function automatic logic [31:0] order_key(input logic [31:0] v);
    logic [31:0] u;
    u = v ^ tks_pkg::VAL_MIN;
    return largest ? ~u : u;
  endfunction

  function automatic logic ahead(input tks_pkg::entry_t x, input tks_pkg::entry_t y);
    logic [31:0] kx;
    logic [31:0] ky;
    kx = order_key(x.value);
    ky = order_key(y.value);
    if (kx != ky) return kx < ky;
    return $signed(x.id) < $signed(y.id);
  endfunction

  function automatic int active_k();
    if (k_reg == 0) return 1;
    if (k_reg > MAX_K) return MAX_K;
    return int'(k_reg);
  endfunction

  task automatic clear_kept();
    for (int i = 0; i < MAX_K; i++) begin
      kept[i].value  = largest ? tks_pkg::VAL_MIN : tks_pkg::VAL_MAX;
      kept[i].id     = tks_pkg::ID_NONE;
      kept[i].attr_a = largest ? tks_pkg::VAL_MIN : tks_pkg::VAL_MAX;
      kept[i].attr_b = largest ? tks_pkg::VAL_MIN : tks_pkg::VAL_MAX;
    end
  endtask

  task automatic absorb_candidate(input tks_pkg::entry_t c, input logic qend);
    int k;
    int p;
    rank_beat_t b;
    k = active_k();
    // strict test against the tail slot; equal values stay out
    if (order_key(c.value) < order_key(kept[k-1].value)) begin
      p = 0;
      while (p < k - 1 && !ahead(c, kept[p])) p++;
      for (int i = k - 1; i > p; i--) kept[i] = kept[i-1];
      kept[p] = c;
    end
    if (qend) begin
      for (int i = 0; i < k; i++) begin
        b.slot = kept[i];
        b.last = (i == k - 1);
        ranked_due.push_back(b);
      end
      clear_kept();
    end
  endtask

  always @(posedge clk) begin : watch
    rank_beat_t      want;
    tks_pkg::entry_t c;
    if (!rst_n) begin
      largest = 1'b0;
      k_reg   = tks_pkg::K_IN_USE_RESET;
      clear_kept();
      ranked_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (ranked_due.size() == 0) begin
          $error("result beat with no expectation: best_id %0d", out_best_id);
          fails++;
        end else begin
          want = ranked_due.pop_front();
          if (out_best_value !== want.slot.value) begin
            $error("best_value: expected %0d, got %0d", want.slot.value, out_best_value);
            fails++;
          end
          if (out_best_id !== want.slot.id) begin
            $error("best_id: expected %0d, got %0d", want.slot.id, out_best_id);
            fails++;
          end
          if (out_best_attr_a !== want.slot.attr_a) begin
            $error("best_attr_a: expected %0d, got %0d", want.slot.attr_a, out_best_attr_a);
            fails++;
          end
          if (out_best_attr_b !== want.slot.attr_b) begin
            $error("best_attr_b: expected %0d, got %0d", want.slot.attr_b, out_best_attr_b);
            fails++;
          end
          if (out_rank_last !== want.last) begin
            $error("rank_last: expected %0d, got %0d", want.last, out_rank_last);
            fails++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tks_pkg::CFG_KEEP_LARGEST) begin
          largest = cfg_wdata[0];
          clear_kept();
        end else if (cfg_index == tks_pkg::CFG_K_IN_USE) begin
          k_reg = cfg_wdata[tks_pkg::K_W-1:0];
          clear_kept();
        end
      end
      if (in_valid && in_ready) begin
        c.value  = in_cand_value;
        c.id     = in_cand_id;
        c.attr_a = in_cand_attr_a;
        c.attr_b = in_cand_attr_b;
        absorb_candidate(c, in_query_end);
      end
    end
    pending = ranked_due.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Stimulus, clocking and verdict for the top-k selector core.
module tb_top;

  typedef logic [tks_pkg::CFG_IDX_W-1:0] cfg_idx_t;

  localparam int MAX_K = 16;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_BEATS = 20;     // random candidates per phase, roughly
  localparam int HOLD_CYCLES = 300;    // long out_ready hold-off for backpressure
  localparam int QUIET_LIMIT = 4000;   // cycles with no beat on any channel
  localparam int SETTLE_CYCLES = 4;    // wait for a trailing candidate to land
  localparam cfg_idx_t CFG_IDX_LAST = '1;
  localparam logic signed [tks_pkg::ID_W-1:0] ID_TOP = 64'sh7FFF_FFFF_FFFF_FFFF;

  // Per-phase register settings: extremes of k (0 acts as 1, above MAX_K clamps).
  localparam bit       PH_MODE [NUM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
  localparam bit [4:0] PH_K    [NUM_PHASES] = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd17, 5'd0};

  logic clk = 1'b0;
  logic rst_n;

  logic                             in_valid;
  logic                             in_ready;
  logic signed [31:0]               in_cand_value;
  logic signed [63:0]               in_cand_id;
  logic signed [31:0]               in_cand_attr_a;
  logic signed [31:0]               in_cand_attr_b;
  logic                             in_query_end;
  logic                             out_valid;
  logic                             out_ready;
  logic signed [31:0]               out_best_value;
  logic signed [63:0]               out_best_id;
  logic signed [31:0]               out_best_attr_a;
  logic signed [31:0]               out_best_attr_b;
  logic                             out_rank_last;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [tks_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [tks_pkg::CFG_DATA_W-1:0]   cfg_wdata;

  int fails;
  int pend;

  // Idle knobs, percent of cycles; hold_len asks the receiver for one long stall.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;
  int quiet = 0;
  logic [4:0] k_set = tks_pkg::K_IN_USE_RESET;

  always #5 clk = ~clk;

  top_k_selector_with_attributes_core #(
    .MAX_K(MAX_K)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cand_value   (in_cand_value),
    .in_cand_id      (in_cand_id),
    .in_cand_attr_a  (in_cand_attr_a),
    .in_cand_attr_b  (in_cand_attr_b),
    .in_query_end    (in_query_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_best_value  (out_best_value),
    .out_best_id     (out_best_id),
    .out_best_attr_a (out_best_attr_a),
    .out_best_attr_b (out_best_attr_b),
    .out_rank_last   (out_rank_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  topk_rank_checker #(
    .MAX_K(MAX_K)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cand_value   (in_cand_value),
    .in_cand_id      (in_cand_id),
    .in_cand_attr_a  (in_cand_attr_a),
    .in_cand_attr_b  (in_cand_attr_b),
    .in_query_end    (in_query_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_best_value  (out_best_value),
    .out_best_id     (out_best_id),
    .out_best_attr_a (out_best_attr_a),
    .out_best_attr_b (out_best_attr_b),
    .out_rank_last   (out_rank_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fails           (fails),
    .pending         (pend)
  );

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Result side: random stalls per phase, plus one long hold-off when asked.
  initial begin : receiver
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len != 0) begin
        n = hold_len;
        hold_len = 0;
        out_ready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic int keff();
    if (k_set == 0) return 1;
    if (k_set > MAX_K) return MAX_K;
    return int'(k_set);
  endfunction

  // Often a tiny pool so ties and duplicates are common, some extremes, else random.
  function automatic logic signed [31:0] pick_value();
    int r;
    int t;
    r = $urandom_range(99);
    t = $urandom_range(6);
    if (r < 35) return t - 3;
    if (r < 45) begin
      case (t % 4)
        0: return tks_pkg::VAL_MIN;
        1: return tks_pkg::VAL_MAX;
        2: return tks_pkg::VAL_MIN + 1;
        default: return tks_pkg::VAL_MAX - 1;
      endcase
    end
    return $urandom;
  endfunction

  // Ids stay in [-1, max]; small ids make value ties resolve by id.
  function automatic logic signed [63:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 10) return tks_pkg::ID_NONE;
    if (r < 50) return 64'($urandom_range(7));
    if (r < 58) return ID_TOP;
    return {1'b0, 31'($urandom), 32'($urandom)};
  endfunction

  // One candidate beat; valid stays up with this payload until taken.
  task automatic send_cand(input logic signed [31:0] v, input logic signed [63:0] id,
                           input logic signed [31:0] a, input logic signed [31:0] b,
                           input logic qend);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_cand_value  = v;
    in_cand_id     = id;
    in_cand_attr_a = a;
    in_cand_attr_b = b;
    in_query_end   = qend;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_random(input logic qend);
    send_cand(pick_value(), pick_id(), $urandom, $urandom, qend);
  endtask

  task automatic write_reg(input logic [tks_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tks_pkg::CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Unused upper wdata bits are randomized; only the low field matters.
  task automatic set_mode(input logic m);
    write_reg(tks_pkg::CFG_KEEP_LARGEST, {7'($urandom), m});
  endtask

  task automatic set_k(input logic [4:0] k);
    k_set = k;
    write_reg(tks_pkg::CFG_K_IN_USE, {3'($urandom), k});
  endtask

  // Drop valid, drain every expected beat, then give a trailing candidate
  // time to land before any register write.
  task automatic settle();
    in_valid = 1'b0;
    while (pend != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int sent;
    int qlen;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cand_value  = '0;
    in_cand_id     = '0;
    in_cand_attr_a = '0;
    in_cand_attr_b = '0;
    in_query_end   = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = tks_pkg::CFG_KEEP_LARGEST;
    cfg_wdata      = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed, reset settings (keep smallest, k = 16).
    send_cand(32'sd5, 64'sd3, tks_pkg::VAL_MIN, tks_pkg::VAL_MAX, 1'b0);
    send_cand(32'sd5, 64'sd1, 32'sh5A5A_0001, 32'sh0000_0001, 1'b0);  // tie: smaller id first
    send_cand(32'sd5, 64'sd1, 32'sh5A5A_0002, 32'sh0000_0002, 1'b0);  // exact dup goes after
    send_cand(tks_pkg::VAL_MIN, ID_TOP, 32'sd0, -32'sd1, 1'b0);
    send_cand(tks_pkg::VAL_MAX, 64'sd0, 32'sh1234_5678, 32'sh0F0F_0F0F, 1'b0); // neutral: out
    send_cand(-32'sd1, tks_pkg::ID_NONE, 32'sh7FFF_0000, 32'sh8000_FFFF, 1'b0); // invalid id
    send_cand(32'sd0, ID_TOP, tks_pkg::VAL_MAX, tks_pkg::VAL_MIN, 1'b0);
    send_cand(tks_pkg::VAL_MAX - 1, tks_pkg::ID_NONE, -32'sd2, 32'sd2, 1'b1);
    // Query with only a neutral candidate: all slots come out empty.
    send_cand(tks_pkg::VAL_MAX, 64'sd9, 32'sd7, 32'sd7, 1'b1);

    settle();
    set_mode(1'b1);
    set_k(5'd2);
    write_reg(CFG_IDX_LAST, '1);                                  // outside the map, ignored
    send_cand(tks_pkg::VAL_MIN, 64'sd0, 32'sd1, 32'sd1, 1'b0);    // neutral for largest
    send_cand(32'sd7, 64'sd4, 32'sd2, 32'sd2, 1'b0);
    send_cand(32'sd7, 64'sd2, 32'sd3, 32'sd3, 1'b0);
    send_cand(32'sd7, 64'sd2, 32'sd4, 32'sd4, 1'b0);              // equals tail value: out
    send_cand(32'sd8, tks_pkg::ID_NONE, tks_pkg::VAL_MIN, tks_pkg::VAL_MAX, 1'b0);
    send_cand(tks_pkg::VAL_MAX, ID_TOP, tks_pkg::VAL_MAX, tks_pkg::VAL_MIN, 1'b1);

    settle();
    set_mode(1'b0);
    set_k(5'd0);                                                  // acts as k = 1
    send_cand(32'sd3, 64'sd5, 32'sd6, 32'sd6, 1'b1);

    // Random phases: each rewrites both registers, then runs whole queries and at times trailing candidates.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      if ($urandom_range(1)) begin
        set_mode(PH_MODE[ph]);
        set_k(PH_K[ph]);
      end else begin
        set_k(PH_K[ph]);
        set_mode(PH_MODE[ph]);
      end
      write_reg(cfg_idx_t'($urandom_range(tks_pkg::CFG_K_IN_USE + 1, CFG_IDX_LAST)),
                8'($urandom));
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 88;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 88;
        end
        default: begin
          send_idle_pct = 15;
          recv_stall_pct = 15;
        end
      endcase
      // Backpressure: receiver stops while candidates keep coming, so the
      // emit of the first query blocks and in_ready drops.
      if (ph == 0) hold_len = HOLD_CYCLES;
      sent = 0;
      while (sent < PHASE_BEATS) begin
        qlen = $urandom_range(1, keff() + 6);
        for (int j = 0; j < qlen; j++) send_random(j == qlen - 1);
        sent += qlen;
      end
      // Trailing candidates with no query end; the next write wipes them.
      if ($urandom_range(2) == 0) begin
        repeat ($urandom_range(1, 3)) send_random(1'b0);
      end
    end

    in_valid = 1'b0;
    while (pend != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
